[rtl/acb_pkg.sv]
// Shared types, codes and constants for the armed config bank block.
// No dependencies; acb_if, acb_ctrl and the top level import this package.
package acb_pkg;

  // Store geometry
  localparam int CFG_DEPTH  = 256;
  localparam int CFG_AW     = 8;
  localparam int CMOS_DEPTH = 128;
  localparam int CMOS_AW    = 7;
  localparam int DATA_W     = 8;

  // Access kinds
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Port codes
  localparam logic [1:0] PORT_CFG_INDEX = 2'd0;
  localparam logic [1:0] PORT_RTC_INDEX = 2'd1;
  localparam logic [1:0] PORT_DATA      = 2'd2;

  // Config entry whose latch bit reads back as clear
  localparam logic [CFG_AW-1:0] LATCH_ENTRY = 8'hFB;
  localparam logic [DATA_W-1:0] LATCH_BIT   = 8'h02;

  // CMOS entries with fixed read values
  localparam logic [CMOS_AW-1:0] CMOS_SEC      = 7'h00;
  localparam logic [CMOS_AW-1:0] CMOS_MIN      = 7'h02;
  localparam logic [CMOS_AW-1:0] CMOS_HOUR     = 7'h04;
  localparam logic [CMOS_AW-1:0] CMOS_WDAY     = 7'h06;
  localparam logic [CMOS_AW-1:0] CMOS_MDAY     = 7'h07;
  localparam logic [CMOS_AW-1:0] CMOS_MONTH    = 7'h08;
  localparam logic [CMOS_AW-1:0] CMOS_YEAR     = 7'h09;
  localparam logic [CMOS_AW-1:0] CMOS_STAT_A   = 7'h0A;
  localparam logic [CMOS_AW-1:0] CMOS_STAT_C   = 7'h0C;
  localparam logic [CMOS_AW-1:0] CMOS_STAT_D   = 7'h0D;
  localparam logic [CMOS_AW-1:0] CMOS_CENTURY  = 7'h32;

  localparam logic [DATA_W-1:0] UIP_MASK = 8'h7F;

  // Controller states
  localparam logic ST_CLEAR = 1'b0;
  localparam logic ST_RUN   = 1'b1;

  // Single-port memory requests
  typedef struct packed {
    logic              we;
    logic              re;
    logic [CFG_AW-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } acb_cfg_req_t;

  typedef struct packed {
    logic               we;
    logic               re;
    logic [CMOS_AW-1:0] addr;
    logic [DATA_W-1:0]  wdata;
  } acb_cmos_req_t;

  // Read value of a CMOS entry: fixed time, status C/D and century bytes win; status A reads with UIP cleared
  function automatic logic [DATA_W-1:0] cmos_read_value(
    input logic [CMOS_AW-1:0] idx,
    input logic [DATA_W-1:0]  stored
  );
    logic [DATA_W-1:0] val;
    case (idx)
      CMOS_SEC:     val = 8'h00;
      CMOS_MIN:     val = 8'h30;
      CMOS_HOUR:    val = 8'h12;
      CMOS_WDAY:    val = 8'h02;
      CMOS_MDAY:    val = 8'h01;
      CMOS_MONTH:   val = 8'h07;
      CMOS_YEAR:    val = 8'h26;
      CMOS_STAT_A:  val = stored & UIP_MASK;
      CMOS_STAT_C:  val = 8'h00;
      CMOS_STAT_D:  val = 8'h80;
      CMOS_CENTURY: val = 8'h20;
      default:      val = stored;
    endcase
    return val;
  endfunction

endpackage

[rtl/acb_if.sv]
// Valid/ready channel interfaces for the bus access and read result beats.
// Depends on acb_pkg for the field widths.
interface acb_in_if import acb_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [1:0]       port_select;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, cmd, port_select, write_data, input ready);
  modport sink   (input valid, cmd, port_select, write_data, output ready);
endinterface

interface acb_out_if import acb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink   (input valid, read_data, output ready);
endinterface

[rtl/acb_ram.sv]
// Generic single-port synchronous RAM with a registered read.
// No package dependency.
module acb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic             re,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one entry per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

[rtl/acb_ctrl.sv]
// Access controller: index registers, arm flag, clearing sweep, memory
// requests, read finishing and the result register. Depends on acb_pkg, acb_if.
module acb_ctrl import acb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  acb_in_if.sink            in_bus,
  acb_out_if.source         out_bus,
  output acb_cfg_req_t      cfg_req,
  output acb_cmos_req_t     cmos_req,
  input  logic [DATA_W-1:0] cfg_rdata,
  input  logic [DATA_W-1:0] cmos_rdata
);

  logic               state_r, state_nxt;
  logic [CFG_AW-1:0]  clr_idx_r, clr_idx_nxt;
  logic [CFG_AW-1:0]  config_index_r, config_index_nxt;
  logic               armed_r, armed_nxt;
  logic [CMOS_AW-1:0] rtc_index_r, rtc_index_nxt;
  logic               pend_r, pend_nxt;
  logic               pend_cfg_r, pend_cfg_nxt;
  logic [CFG_AW-1:0]  pend_idx_r, pend_idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]  out_data_r, out_data_nxt;

  logic              accept;
  logic              is_wr;
  logic              is_data;
  logic              data_rd;
  logic              data_wr;
  logic [DATA_W-1:0] direct_res;
  logic [DATA_W-1:0] mem_res;
  logic              clearing;

  assign clearing = (state_r == ST_CLEAR);

  // Take a beat only after the sweep, with nothing in flight and room in the result register
  assign in_bus.ready = !clearing && !pend_r && (!out_valid_r || out_bus.ready);
  assign accept       = in_bus.valid && in_bus.ready;

  assign is_wr   = (in_bus.cmd == CMD_WRITE);
  assign is_data = (in_bus.port_select == PORT_DATA);
  assign data_rd = accept && !is_wr && is_data;
  assign data_wr = accept && is_wr && is_data;

  // Drive the memory ports: sweep zeros after reset, else the selected store
  always_comb begin
    cfg_req.we    = clearing || (data_wr && armed_r);
    cfg_req.re    = data_rd && armed_r;
    cfg_req.addr  = clearing ? clr_idx_r : config_index_r;
    cfg_req.wdata = clearing ? '0 : in_bus.write_data;

    cmos_req.we    = clearing || (data_wr && !armed_r);
    cmos_req.re    = data_rd && !armed_r;
    cmos_req.addr  = clearing ? clr_idx_r[CMOS_AW-1:0] : rtc_index_r;
    cmos_req.wdata = clearing ? '0 : in_bus.write_data;
  end

  // Result of accesses that need no memory read
  always_comb begin
    direct_res = '0;
    if (!is_wr) begin
      case (in_bus.port_select)
        PORT_CFG_INDEX: direct_res = config_index_r;
        PORT_RTC_INDEX: direct_res = {1'b0, rtc_index_r};
        default:        direct_res = '0;
      endcase
    end
  end

  // Finish a data-port read from the store that was selected at issue
  always_comb begin
    if (pend_cfg_r) begin
      mem_res = (pend_idx_r == LATCH_ENTRY) ? (cfg_rdata & ~LATCH_BIT) : cfg_rdata;
    end else begin
      mem_res = cmos_read_value(pend_idx_r[CMOS_AW-1:0], cmos_rdata);
    end
  end

  // Advance the index registers, the sweep, the pending read and the result
  always_comb begin
    state_nxt        = state_r;
    clr_idx_nxt      = clr_idx_r;
    config_index_nxt = config_index_r;
    armed_nxt        = armed_r;
    rtc_index_nxt    = rtc_index_r;
    pend_nxt         = 1'b0;
    pend_cfg_nxt     = pend_cfg_r;
    pend_idx_nxt     = pend_idx_r;
    out_valid_nxt    = out_valid_r;
    out_data_nxt     = out_data_r;

    if (clearing) begin
      clr_idx_nxt = clr_idx_r + 1'b1;
      if (clr_idx_r == CFG_AW'(CFG_DEPTH - 1)) begin
        state_nxt = ST_RUN;
      end
    end

    if (out_valid_r && out_bus.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (accept) begin
      if (is_wr && in_bus.port_select == PORT_CFG_INDEX) begin
        config_index_nxt = in_bus.write_data;
        armed_nxt        = 1'b1;
      end
      if (is_wr && in_bus.port_select == PORT_RTC_INDEX) begin
        rtc_index_nxt = in_bus.write_data[CMOS_AW-1:0];
        armed_nxt     = 1'b0;
      end
      if (data_rd) begin
        pend_nxt     = 1'b1;
        pend_cfg_nxt = armed_r;
        pend_idx_nxt = armed_r ? config_index_r : {1'b0, rtc_index_r};
      end else begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = direct_res;
      end
    end

    if (pend_r) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = mem_res;
    end
  end

  // Hold control state under reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      clr_idx_r      <= '0;
      config_index_r <= '0;
      armed_r        <= 1'b0;
      rtc_index_r    <= '0;
      pend_r         <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      clr_idx_r      <= clr_idx_nxt;
      config_index_r <= config_index_nxt;
      armed_r        <= armed_nxt;
      rtc_index_r    <= rtc_index_nxt;
      pend_r         <= pend_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pend_cfg_r <= pend_cfg_nxt;
    pend_idx_r <= pend_idx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_bus.valid     = out_valid_r;
  assign out_bus.read_data = out_data_r;

endmodule

[rtl/armed_config_bank_over_rtc_ports_unit.sv]
// Top level: the access controller with the 256-byte config bank and the
// 128-byte CMOS store. Depends on acb_pkg, acb_if, acb_ram and acb_ctrl.

// Each beat on in_bus is one byte access to the config index port, the RTC
// index port or the shared data port, and gives exactly one beat on out_bus.
// Index-port accesses and all writes go straight to the result register; a
// data-port read first passes the selected bank, a single-port RAM with a
// registered read, and the next beat is taken once that read has landed in
// the result register. The result register holds a finished beat while
// out_bus stalls; a new beat is taken no earlier than the cycle in which
// that beat leaves. After reset both stores are zeroed by a clearing sweep,
// one entry per cycle, during which in_bus.ready stays low.
module armed_config_bank_over_rtc_ports_unit import acb_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  acb_in_if.sink    in_bus,
  acb_out_if.source out_bus
);

  acb_cfg_req_t      cfg_req;
  acb_cmos_req_t     cmos_req;
  logic [DATA_W-1:0] cfg_rdata;
  logic [DATA_W-1:0] cmos_rdata;

  acb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .out_bus    (out_bus),
    .cfg_req    (cfg_req),
    .cmos_req   (cmos_req),
    .cfg_rdata  (cfg_rdata),
    .cmos_rdata (cmos_rdata)
  );

  // Config bank
  acb_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CFG_DEPTH)
  ) u_cfg_ram (
    .clk   (clk),
    .we    (cfg_req.we),
    .re    (cfg_req.re),
    .addr  (cfg_req.addr),
    .wdata (cfg_req.wdata),
    .rdata (cfg_rdata)
  );

  // CMOS store
  acb_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CMOS_DEPTH)
  ) u_cmos_ram (
    .clk   (clk),
    .we    (cmos_req.we),
    .re    (cmos_req.re),
    .addr  (cmos_req.addr),
    .wdata (cmos_req.wdata),
    .rdata (cmos_rdata)
  );

endmodule
